FILE: src/vcis_pkg.sv
package vcis_pkg;

    localparam int CACHE_DEPTH = 32;
    localparam int SLOT_W = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
    localparam int CNT_W = $clog2(CACHE_DEPTH + 1);

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESTART = 2'd2;

    localparam logic [CFG_DATA_W-1:0] ENTRIES_RESET = 6'd32;

    localparam logic [31:0] RESTART_SHORT = 32'h0000FFFF;
    localparam logic [31:0] RESTART_LONG = 32'hFFFFFFFF;
    localparam logic [31:0] ALL_ONES = 32'hFFFFFFFF;

    typedef struct packed {
        logic              valid;
        logic [31:0]       value;
        logic [31:0]       pos;
        logic [CNT_W-1:0]  filled;
        logic              hit;
        logic              have;
        logic [31:0]       min_age;
        logic [SLOT_W-1:0] victim;
    } scan_tok_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        logic [31:0]       value;
        logic [31:0]       age;
    } slot_wr_t;

    function automatic logic [31:0] sat_inc(input logic [31:0] x);
        logic [31:0] r;
        if (x == ALL_ONES)
        begin
            r = x;
        end
        else
        begin
            r = x + 32'd1;
        end
        return r;
    endfunction

endpackage

FILE: src/vcis_cell.sv
module vcis_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [vcis_pkg::SLOT_W-1:0] slot_id,
    input  vcis_pkg::scan_tok_t       tok_in,
    input  vcis_pkg::slot_wr_t        wr,
    output vcis_pkg::scan_tok_t       tok_out
);
    import vcis_pkg::*;

    logic [31:0] index_reg;
    logic [31:0] age_reg;
    scan_tok_t   tok_reg;
    scan_tok_t   tok_next;
    logic        active;
    logic        match;
    logic        older;

    assign active = CNT_W'(slot_id) < tok_in.filled;
    assign match = tok_in.valid && active && !tok_in.hit && (index_reg == tok_in.value);
    assign older = tok_in.valid && active && !tok_in.hit
                   && (!tok_in.have || (age_reg < tok_in.min_age));

    always_comb
    begin
        tok_next = tok_in;
        if (match)
        begin
            tok_next.hit = 1'b1;
        end
        if (older)
        begin
            tok_next.have = 1'b1;
            tok_next.min_age = age_reg;
            tok_next.victim = slot_id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    // slot contents, written by the fill/replace port or refreshed on a hit
    always_ff @(posedge clk)
    begin
        if (wr.en && (wr.slot == slot_id))
        begin
            index_reg <= wr.value;
            age_reg <= wr.age;
        end
        else if (match)
        begin
            age_reg <= tok_in.pos;
        end
    end

    assign tok_out = tok_reg;

endmodule

FILE: src/vertex_cache_index_scanner.sv
// vertex_cache_index_scanner
// Simulates an LRU post-transform vertex cache over a stream of draw indices.
// Input channel (in_valid/in_ready): one index word per item, with flags that
// open and close a draw. Output channel (out_valid/out_ready): one result word
// per input word, with hit/skip flags and the running miss count, min and max.
// Configuration channel (cfg_valid/cfg_ready, always ready): index 0 sets the
// slot count, 1 selects 16-bit indices, 2 enables restart skipping; write only
// while the block is idle.
// A lookup token walks a chain of CACHE_DEPTH slot cells, one cell per cycle;
// when it leaves the last cell a miss writes the victim or fill slot and the
// block moves to the done state, loads the output register and returns to
// idle. A skipped restart word goes from accept straight to the done state.
// One word is in flight at a time; the result sits in an output register, and
// the next word is accepted while it waits. If the receiver stalls, the
// following result waits until the output register is free.
// Reset clears the counters, presets min/max and restores the default configuration; slot contents are
// left unknown until written by misses.
module vertex_cache_index_scanner (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [5:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] index_value,
    input  logic        first_of_draw,
    input  logic        last_of_draw,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        was_hit,
    output logic        was_skipped,
    output logic [31:0] miss_total,
    output logic [31:0] min_seen,
    output logic [31:0] max_seen,
    output logic        end_of_draw
);
    import vcis_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [CFG_DATA_W-1:0] entries_reg;
    logic                  short_reg;
    logic                  restart_en_reg;

    logic [31:0] position_reg;
    logic [31:0] miss_count_reg;
    logic [31:0] run_min_reg;
    logic [31:0] run_max_reg;
    logic        out_valid_reg;

    logic [31:0]       v_reg;
    logic [31:0]       age_reg;
    logic              last_reg;
    logic              skip_reg;
    logic              hit_reg;
    logic              fill_reg;
    logic [SLOT_W-1:0] fill_slot_reg;

    logic        was_hit_reg;
    logic        was_skipped_reg;
    logic [31:0] miss_total_reg;
    logic [31:0] min_seen_reg;
    logic [31:0] max_seen_reg;
    logic        end_of_draw_reg;

    logic             in_accept;
    logic [31:0]      v_in;
    logic [31:0]      restart_val;
    logic             skip_in;
    logic [31:0]      pos_eff;
    logic [31:0]      miss_eff;
    logic [31:0]      min_eff;
    logic [31:0]      max_eff;
    logic [CNT_W-1:0] size_cnt;
    logic             fill_in;
    logic [CNT_W-1:0] filled_in;
    logic             scan_end;
    logic             out_load;

    scan_tok_t chain [0:CACHE_DEPTH];
    scan_tok_t tail;
    slot_wr_t  wr;

    assign cfg_ready = 1'b1;
    assign in_ready = (state_reg == S_IDLE);
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        v_in = short_reg ? {16'h0000, index_value[15:0]} : index_value;
        restart_val = short_reg ? RESTART_SHORT : RESTART_LONG;
        skip_in = restart_en_reg && (v_in == restart_val);
        pos_eff = first_of_draw ? 32'd0 : position_reg;
        miss_eff = first_of_draw ? 32'd0 : miss_count_reg;
        min_eff = first_of_draw ? ALL_ONES : run_min_reg;
        max_eff = first_of_draw ? 32'd0 : run_max_reg;
        if (entries_reg == '0)
        begin
            size_cnt = CNT_W'(1);
        end
        else if (32'(entries_reg) > 32'(CACHE_DEPTH))
        begin
            size_cnt = CNT_W'(CACHE_DEPTH);
        end
        else
        begin
            size_cnt = CNT_W'(entries_reg);
        end
        fill_in = pos_eff < 32'(size_cnt);
        filled_in = fill_in ? CNT_W'(pos_eff) : size_cnt;
    end

    always_comb
    begin
        chain[0].valid = in_accept && !skip_in;
        chain[0].value = v_in;
        chain[0].pos = pos_eff;
        chain[0].filled = filled_in;
        chain[0].hit = 1'b0;
        chain[0].have = 1'b0;
        chain[0].min_age = '0;
        chain[0].victim = '0;
    end

    assign tail = chain[CACHE_DEPTH];
    assign scan_end = (state_reg == S_SCAN) && tail.valid;

    always_comb
    begin
        wr.en = scan_end && !tail.hit;
        wr.slot = fill_reg ? fill_slot_reg : tail.victim;
        wr.value = v_reg;
        wr.age = age_reg;
    end

    genvar gi;
    generate
        for (gi = 0; gi < CACHE_DEPTH; gi++)
        begin : g_cell
            vcis_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .slot_id (SLOT_W'(gi)),
                .tok_in  (chain[gi]),
                .wr      (wr),
                .tok_out (chain[gi+1])
            );
        end
    endgenerate

    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = skip_in ? S_DONE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (tail.valid)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            entries_reg <= ENTRIES_RESET;
            short_reg <= 1'b0;
            restart_en_reg <= 1'b0;
            position_reg <= '0;
            miss_count_reg <= '0;
            run_min_reg <= ALL_ONES;
            run_max_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ENTRIES: entries_reg <= cfg_data;
                    CFG_SHORT:   short_reg <= cfg_data[0];
                    CFG_RESTART: restart_en_reg <= cfg_data[0];
                    default:     ;
                endcase
            end
            if (in_accept)
            begin
                miss_count_reg <= miss_eff;
                if (skip_in)
                begin
                    position_reg <= pos_eff;
                    run_min_reg <= min_eff;
                    run_max_reg <= max_eff;
                end
                else
                begin
                    position_reg <= sat_inc(pos_eff);
                    run_min_reg <= (v_in < min_eff) ? v_in : min_eff;
                    run_max_reg <= (v_in > max_eff) ? v_in : max_eff;
                end
            end
            else if (scan_end && !tail.hit)
            begin
                miss_count_reg <= sat_inc(miss_count_reg);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            v_reg <= v_in;
            age_reg <= pos_eff;
            last_reg <= last_of_draw;
            skip_reg <= skip_in;
            hit_reg <= 1'b0;
            fill_reg <= fill_in;
            fill_slot_reg <= SLOT_W'(pos_eff);
        end
        else if (scan_end)
        begin
            hit_reg <= tail.hit;
        end
        if (out_load)
        begin
            was_hit_reg <= hit_reg;
            was_skipped_reg <= skip_reg;
            miss_total_reg <= miss_count_reg;
            min_seen_reg <= run_min_reg;
            max_seen_reg <= run_max_reg;
            end_of_draw_reg <= last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign was_hit = was_hit_reg;
    assign was_skipped = was_skipped_reg;
    assign miss_total = miss_total_reg;
    assign min_seen = min_seen_reg;
    assign max_seen = max_seen_reg;
    assign end_of_draw = end_of_draw_reg;

endmodule

FILE: tb/vertex_cache_index_scanner_tb.sv
module vertex_cache_index_scanner_tb;
    import vcis_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = CACHE_DEPTH + 8;
    localparam int ITEM_TARGET = 950;

    typedef struct packed {
        logic        hit;
        logic        skipped;
        logic [31:0] misses;
        logic [31:0] lowest;
        logic [31:0] highest;
        logic        last;
    } scan_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [31:0]           index_value;
    logic                  first_of_draw;
    logic                  last_of_draw;
    logic                  out_valid;
    logic                  out_ready;
    logic                  was_hit;
    logic                  was_skipped;
    logic [31:0]           miss_total;
    logic [31:0]           min_seen;
    logic [31:0]           max_seen;
    logic                  end_of_draw;

    scan_result_t          pending_results[$];
    logic [31:0]           slot_value [CACHE_DEPTH];
    logic [31:0]           slot_age [CACHE_DEPTH];
    bit                    slot_written [CACHE_DEPTH];
    logic [31:0]           draw_pos;
    logic [31:0]           draw_misses;
    logic [31:0]           draw_min;
    logic [31:0]           draw_max;
    logic [CFG_DATA_W-1:0] entries_reg;
    logic                  short_reg;
    logic                  restart_reg;
    bit                    draw_reset_due;
    bit                    in_idle_on;
    bit                    out_idle_on;
    int                    items_sent = 0;
    int                    mismatch_count = 0;
    int                    quiet_cycles = 0;

    vertex_cache_index_scanner i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .index_value   (index_value),
        .first_of_draw (first_of_draw),
        .last_of_draw  (last_of_draw),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .was_hit       (was_hit),
        .was_skipped   (was_skipped),
        .miss_total    (miss_total),
        .min_seen      (min_seen),
        .max_seen      (max_seen),
        .end_of_draw   (end_of_draw)
    );

    always #5 clk = ~clk;

    function automatic int slots_in_use();
        int n;
        n = int'(entries_reg);
        if (n < 1)
        begin
            n = 1;
        end
        if (n > CACHE_DEPTH)
        begin
            n = CACHE_DEPTH;
        end
        return n;
    endfunction

    function automatic logic [31:0] masked_index(input logic [31:0] raw);
        return short_reg ? {16'h0000, raw[15:0]} : raw;
    endfunction

    function automatic bit is_restart(input logic [31:0] v);
        return restart_reg && (v == (short_reg ? RESTART_SHORT : RESTART_LONG));
    endfunction

    // slot holding v among those searched at position p, or -1
    function automatic int find_slot(input logic [31:0] v, input logic [31:0] p);
        int filled;
        int found;
        int i;
        filled = (p < slots_in_use()) ? int'(p) : slots_in_use();
        found = -1;
        for (i = 0; i < filled; i++)
        begin
            if (found < 0 && slot_value[i] == v)
            begin
                found = i;
            end
        end
        return found;
    endfunction

    // a hit while filling would leave a never-written slot in the search range
    function automatic logic [31:0] safe_index(input logic [31:0] raw, input logic first);
        logic [31:0] p;
        logic [31:0] v;
        v = raw;
        p = first ? 32'd0 : draw_pos;
        if (p < slots_in_use() && !slot_written[p] && !is_restart(masked_index(v)))
        begin
            while (find_slot(masked_index(v), p) >= 0 || is_restart(masked_index(v)))
            begin
                v = $urandom;
            end
        end
        return v;
    endfunction

    function automatic scan_result_t predict_scan(input logic [31:0] raw, input logic first,
                                                  input logic last);
        scan_result_t r;
        logic [31:0]  v;
        int           size;
        int           filled;
        int           victim;
        int           slot;
        int           i;
        v = masked_index(raw);
        if (first)
        begin
            draw_pos = '0;
            draw_misses = '0;
            draw_min = ALL_ONES;
            draw_max = '0;
        end
        r = '0;
        r.last = last;
        if (is_restart(v))
        begin
            r.skipped = 1'b1;
        end
        else
        begin
            if (v < draw_min)
            begin
                draw_min = v;
            end
            if (v > draw_max)
            begin
                draw_max = v;
            end
            size = slots_in_use();
            filled = (draw_pos < size) ? int'(draw_pos) : size;
            slot = find_slot(v, draw_pos);
            if (slot >= 0)
            begin
                slot_age[slot] = draw_pos;
                r.hit = 1'b1;
            end
            else
            begin
                victim = 0;
                for (i = 0; i < filled; i++)
                begin
                    if (slot_age[i] < slot_age[victim])
                    begin
                        victim = i;
                    end
                end
                if (draw_pos < size)
                begin
                    victim = int'(draw_pos);
                end
                slot_value[victim] = v;
                slot_age[victim] = draw_pos;
                slot_written[victim] = 1'b1;
                if (draw_misses != ALL_ONES)
                begin
                    draw_misses = draw_misses + 32'd1;
                end
            end
            if (draw_pos != ALL_ONES)
            begin
                draw_pos = draw_pos + 32'd1;
            end
        end
        r.misses = draw_misses;
        r.lowest = draw_min;
        r.highest = draw_max;
        return r;
    endfunction

    task automatic send_index(input logic [31:0] raw, input logic first, input logic last);
        int          gap;
        logic        first_eff;
        logic [31:0] v;
        gap = in_idle_on ? $urandom_range(0, 5) : 0;
        first_eff = first | draw_reset_due;
        v = safe_index(raw, first_eff);
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        index_value <= v;
        first_of_draw <= first_eff;
        last_of_draw <= last;
        do @(posedge clk); while (!in_ready);
        pending_results = {pending_results, predict_scan(v, first_eff, last)};
        draw_reset_due = 1'b0;
        items_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_ENTRIES: entries_reg = data;
            CFG_SHORT:   short_reg = data[0];
            CFG_RESTART: restart_reg = data[0];
            default:     ;
        endcase
        draw_reset_due = 1'b1;
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] entries, input logic short_idx,
                              input logic restart);
        wait_drained();
        write_reg(CFG_ENTRIES, entries);
        write_reg(CFG_SHORT, {5'($urandom), short_idx});
        write_reg(CFG_RESTART, {5'($urandom), restart});
        if ($urandom_range(0, 3) == 0)
        begin
            write_reg(CFG_UNUSED, 6'($urandom));
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_default_config();
        send_index(32'h0000_0000, 1'b1, 1'b0);
        send_index(ALL_ONES, 1'b0, 1'b0);
        send_index(32'h8000_0000, 1'b0, 1'b0);
        send_index(32'h7FFF_FFFF, 1'b0, 1'b0);
        send_index(32'h0000_0000, 1'b0, 1'b1);
    endtask

    task automatic test_restart_skip();
        set_config(6'd4, 1'b0, 1'b1);
        send_index(ALL_ONES, 1'b1, 1'b0);
        send_index(32'h0000_0005, 1'b0, 1'b0);
        send_index(ALL_ONES, 1'b0, 1'b0);
        send_index(32'h0000_0005, 1'b0, 1'b0);
        send_index(32'h0000_FFFF, 1'b0, 1'b1);
    endtask

    task automatic test_short_index();
        set_config(6'd4, 1'b1, 1'b1);
        send_index(32'hABCD_FFFF, 1'b1, 1'b0);
        send_index(32'h0001_0002, 1'b0, 1'b0);
        send_index(32'hFFFF_0002, 1'b0, 1'b0);
        send_index(32'hFFFF_FFFE, 1'b0, 1'b1);
        set_config(6'd4, 1'b1, 1'b0);
        send_index(32'h1234_FFFF, 1'b1, 1'b1);
    endtask

    task automatic test_slot_count_extremes();
        // zero acts as one slot, above the depth acts as the full depth
        set_config(6'd0, 1'b0, 1'b0);
        send_index(32'h0000_0010, 1'b1, 1'b0);
        send_index(32'h0000_0020, 1'b0, 1'b0);
        send_index(32'h0000_0010, 1'b0, 1'b1);
        set_config(6'd63, 1'b0, 1'b0);
        send_index(32'h0000_0001, 1'b1, 1'b0);
        send_index(32'h0000_0002, 1'b0, 1'b0);
        send_index(32'h0000_0001, 1'b0, 1'b1);
    endtask

    task automatic test_random_draws();
        int                    len;
        int                    pool;
        int                    k;
        int                    pick;
        logic [31:0]           base;
        logic [31:0]           v;
        logic                  first;
        logic                  last;
        logic [CFG_DATA_W-1:0] entries;
        while (items_sent < ITEM_TARGET)
        begin
            case ($urandom_range(0, 5))
                0:       entries = 6'd1;
                1:       entries = 6'd32;
                2:       entries = 6'($urandom_range(2, 8));
                3:       entries = 6'($urandom_range(9, 31));
                4:       entries = 6'($urandom_range(33, 63));
                default: entries = 6'($urandom);
            endcase
            set_config(entries, 1'($urandom), 1'($urandom));
            in_idle_on = $urandom_range(0, 3) != 0;
            out_idle_on = $urandom_range(0, 3) != 0;
            repeat ($urandom_range(2, 4))
            begin
                len = $urandom_range(1, 2 * slots_in_use() + 8);
                pool = slots_in_use() + $urandom_range(0, slots_in_use() + 2);
                base = $urandom;
                for (k = 0; k < len && items_sent < ITEM_TARGET; k++)
                begin
                    pick = $urandom_range(0, 19);
                    if (pick < 16)
                    begin
                        v = base + $urandom_range(0, pool - 1);
                    end
                    else if (pick < 18)
                    begin
                        v = short_reg ? {16'($urandom), 16'hFFFF} : ALL_ONES;
                    end
                    else
                    begin
                        v = $urandom;
                    end
                    // mostly well-formed draws, with stray and missing flags mixed in
                    if (k == 0)
                    begin
                        first = $urandom_range(0, 9) != 0;
                    end
                    else
                    begin
                        first = $urandom_range(0, 29) == 0;
                    end
                    if (k == len - 1)
                    begin
                        last = $urandom_range(0, 9) != 0;
                    end
                    else
                    begin
                        last = $urandom_range(0, 29) == 0;
                    end
                    send_index(v, first, last);
                end
            end
        end
    endtask

    initial
    begin
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = out_idle_on ? $urandom_range(0, 5) : 0;
            @(negedge clk);
            if (stall == 0)
            begin
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b0;
                do @(posedge clk); while (!out_valid);
                repeat (stall) @(negedge clk);
                out_ready <= 1'b1;
            end
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        scan_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $display("result word with nothing pending: miss_total %h", miss_total);
                end
            end
            else
            begin
                want = pending_results.pop_front();
                if (was_hit !== want.hit || was_skipped !== want.skipped
                    || miss_total !== want.misses || min_seen !== want.lowest
                    || max_seen !== want.highest || end_of_draw !== want.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("mismatch: expected hit %b skip %b miss %h min %h max %h end %b",
                                 want.hit, want.skipped, want.misses, want.lowest,
                                 want.highest, want.last);
                        $display("          actual   hit %b skip %b miss %h min %h max %h end %b",
                                 was_hit, was_skipped, miss_total, min_seen, max_seen,
                                 end_of_draw);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        index_value = '0;
        first_of_draw = 1'b0;
        last_of_draw = 1'b0;
        entries_reg = ENTRIES_RESET;
        short_reg = 1'b0;
        restart_reg = 1'b0;
        draw_pos = '0;
        draw_misses = '0;
        draw_min = ALL_ONES;
        draw_max = '0;
        draw_reset_due = 1'b0;
        in_idle_on = 1'b1;
        out_idle_on = 1'b1;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_config();
        test_restart_skip();
        test_short_index();
        test_slot_count_extremes();
        test_random_draws();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: files.f
src/vcis_pkg.sv
src/vcis_cell.sv
src/vertex_cache_index_scanner.sv
tb/vertex_cache_index_scanner_tb.sv
